@@ src/fsg_pkg.sv @@
package fsg_pkg;

    typedef struct packed {
        logic accept;
        logic emit;
        logic div_step;
        logic mul_num;
        logic mul_den;
        logic update;
    } fsg_cmd_t;

    typedef struct packed {
        logic out_free;
        logic advance;
    } fsg_status_t;

endpackage

@@ src/farey_sequence_generator.sv @@
// Farey sequence generator: each input transfer asks for one term of the Farey
// sequence of order max_denominator (0 is taken as 1), emitted in ascending order
// from 0/1 to 1/1 as a numerator/denominator pair, with m_tlast set on 1/1; the
// term after 1/1 is 0/1 again, and restart set in a request gives 0/1 at once.
// A request is taken while the block is idle and its term is issued once the
// output register is free; the block then prepares the following term, paced
// by the restoring divider that finds floor((N + b) / d) one bit per cycle,
// followed by two passes through one shared multiplier and an update step.
// The first term of a run and the term 1/1 need no preparation.
// Write max_denominator only while the block is idle.
module farey_sequence_generator #(
    parameter int DENOM_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,    // max_denominator
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // restart, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // numerator, denominator
    output logic        m_tlast
);

    fsg_pkg::fsg_cmd_t    cmd;
    fsg_pkg::fsg_status_t status;

    assign cfg_ready = 1'b1;

    fsg_controller #(
        .DENOM_WIDTH(DENOM_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    fsg_datapath #(
        .DENOM_WIDTH(DENOM_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/fsg_datapath.sv @@
module fsg_datapath #(
    parameter int DENOM_WIDTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fsg_pkg::fsg_cmd_t   cmd,
    output fsg_pkg::fsg_status_t status,
    input  logic [7:0]          s_tdata,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tlast
);

    localparam int W  = DENOM_WIDTH;
    localparam int PW = 2 * W + 1;
    localparam int SW = 2 * W + 2;

    logic [7:0]    max_den_reg;
    logic          restart_reg;
    logic          at_start_reg;
    logic [W-1:0]  prev_num_reg, prev_den_reg, cur_num_reg, cur_den_reg;
    logic [W-1:0]  rem_reg;
    logic [W:0]    quo_reg;
    logic [PW-1:0] kc_reg, kd_reg;
    logic          m_tvalid_reg;
    logic [7:0]    out_num_reg, out_den_reg;
    logic          out_last_reg;

    logic [W+7:0]  cfg_ext;
    logic [W-1:0]  order_n;
    logic          starting, cur_is_one;
    logic [W:0]    dividend;
    logic [W:0]    trial, trial_diff;
    logic          trial_ge;
    logic [W-1:0]  mul_operand;
    logic [PW-1:0] product;
    logic signed [SW-1:0] p_s, q_s, one_s, dmask_s, zero_s;
    logic          term_ok;
    logic [W+7:0]  cur_num_ext, cur_den_ext;

    assign cfg_ext = {{W{1'b0}}, max_den_reg};
    assign order_n = (cfg_ext[W-1:0] == '0) ? W'(1) : cfg_ext[W-1:0];

    assign starting   = restart_reg || at_start_reg;
    assign cur_is_one = (cur_num_reg == W'(1)) && (cur_den_reg == W'(1));
    assign dividend   = {1'b0, order_n} + {1'b0, prev_den_reg};

    assign trial      = {rem_reg, quo_reg[W]};
    assign trial_ge   = trial >= {1'b0, cur_den_reg};
    assign trial_diff = trial - {1'b0, cur_den_reg};

    assign mul_operand = cmd.mul_den ? cur_den_reg : cur_num_reg;
    assign product     = PW'(quo_reg) * PW'(mul_operand);

    assign zero_s  = '0;
    assign one_s   = SW'(1);
    assign dmask_s = SW'((2 ** W) - 1);
    assign p_s = $signed({1'b0, kc_reg}) - $signed({{(W + 2){1'b0}}, prev_num_reg});
    assign q_s = $signed({1'b0, kd_reg}) - $signed({{(W + 2){1'b0}}, prev_den_reg});
    assign term_ok = (cur_den_reg != '0) && (q_s >= one_s) && (q_s <= dmask_s)
                     && (p_s >= zero_s) && (p_s < q_s);

    assign cur_num_ext = {8'd0, cur_num_reg};
    assign cur_den_ext = {8'd0, cur_den_reg};

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign status.advance  = !starting && !cur_is_one;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_den_reg, out_num_reg};
    assign m_tlast  = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_den_reg  <= 8'd1;
            restart_reg  <= 1'b0;
            at_start_reg <= 1'b1;
            prev_num_reg <= '0;
            prev_den_reg <= W'(1);
            cur_num_reg  <= '0;
            cur_den_reg  <= W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_den_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cmd.accept) begin
                restart_reg <= s_tdata[0];
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
                if (starting) begin
                    prev_num_reg <= '0;
                    prev_den_reg <= W'(1);
                    cur_num_reg  <= W'(1);
                    cur_den_reg  <= order_n;
                    at_start_reg <= 1'b0;
                end else if (cur_is_one) begin
                    prev_num_reg <= '0;
                    prev_den_reg <= W'(1);
                    cur_num_reg  <= '0;
                    cur_den_reg  <= W'(1);
                    at_start_reg <= 1'b1;
                end
            end
            if (cmd.update) begin
                prev_num_reg <= cur_num_reg;
                prev_den_reg <= cur_den_reg;
                cur_num_reg  <= term_ok ? p_s[W-1:0] : W'(1);
                cur_den_reg  <= term_ok ? q_s[W-1:0] : W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_num_reg  <= starting ? 8'd0 : cur_num_ext[7:0];
            out_den_reg  <= starting ? 8'd1 : cur_den_ext[7:0];
            out_last_reg <= !starting && cur_is_one;
            rem_reg      <= '0;
            quo_reg      <= dividend;
        end
        if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_diff[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_reg[W-1:0], trial_ge};
        end
        if (cmd.mul_num) begin
            kc_reg <= product;
        end
        if (cmd.mul_den) begin
            kd_reg <= product;
        end
    end

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before transfer");
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> (cur_den_reg != '0) && (cur_num_reg < cur_den_reg || cur_is_one))
        else $error("invalid next term");
    a_last_is_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_last_reg) |-> (out_num_reg == 8'd1 && out_den_reg == 8'd1))
        else $error("last flag on a term other than 1/1");
`endif

endmodule

@@ src/fsg_controller.sv @@
module fsg_controller #(
    parameter int DENOM_WIDTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  fsg_pkg::fsg_status_t status,
    output fsg_pkg::fsg_cmd_t    cmd
);

    localparam int CNT_W = $clog2(DENOM_WIDTH + 2);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DENOM_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_DIV,
        S_MULC,
        S_MULD,
        S_UPD
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd          = '0;
        cmd.accept   = (state_reg == S_IDLE) && s_tvalid;
        cmd.emit     = (state_reg == S_EMIT) && status.out_free;
        cmd.div_step = (state_reg == S_DIV);
        cmd.mul_num  = (state_reg == S_MULC);
        cmd.mul_den  = (state_reg == S_MULD);
        cmd.update   = (state_reg == S_UPD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    cnt_reg <= '0;
                    if (status.out_free) begin
                        state_reg <= status.advance ? S_DIV : S_IDLE;
                    end
                end
                S_DIV: begin
                    if (cnt_reg == LAST_STEP) begin
                        state_reg <= S_MULC;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_MULC: state_reg <= S_MULD;
                S_MULD: state_reg <= S_UPD;
                S_UPD:  state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && cnt_reg == LAST_STEP) |=> (state_reg == S_MULC))
        else $error("divider did not hand over to multiply");
    a_upd_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |-> ($past(state_reg) == S_MULD))
        else $error("update without both products");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (cnt_reg <= LAST_STEP))
        else $error("divider step count out of range");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int DENOM_WIDTH    = 8;
    localparam int DENOM_MAX      = (1 << DENOM_WIDTH) - 1;
    localparam int SETTLE_CYCLES  = DENOM_WIDTH + 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 650;
    localparam int QUIET_FROM     = 560;

    typedef struct packed {
        logic [7:0] numer;
        logic [7:0] denom;
        logic       last;
    } farey_term_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // restart, zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // numerator, denominator
    logic        m_tlast;

    farey_sequence_generator #(
        .DENOM_WIDTH(DENOM_WIDTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    logic        restart_q[$];
    farey_term_t term_q[$];
    farey_term_t due_term;
    int          mismatches = 0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    int          stall_cycles = 0;
    int          sent = 0;

    // predictor state: last emitted term and the term to emit next
    logic [7:0]  order_n = 8'd1;
    logic [7:0]  emitted_num = 8'd0;
    logic [7:0]  emitted_den = 8'd1;
    logic [7:0]  pending_num = 8'd0;
    logic [7:0]  pending_den = 8'd1;
    logic        fresh = 1'b1;

    logic push_list_a[6] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    logic push_list_b[4] = '{1'b0, 1'b0, 1'b1, 1'b0};
    logic push_list_c[8] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};

    function automatic farey_term_t farey_next_term(input logic restart);
        farey_term_t t;
        int n, k, p, q;
        n = (order_n == 8'd0) ? 1 : int'(order_n);
        if (restart || fresh) begin
            t = '{numer: 8'd0, denom: 8'd1, last: 1'b0};
            emitted_num = 8'd0;
            emitted_den = 8'd1;
            pending_num = 8'd1;
            pending_den = n[7:0];
            fresh = 1'b0;
        end else begin
            t.numer = pending_num;
            t.denom = pending_den;
            t.last  = (pending_num == 8'd1) && (pending_den == 8'd1);
            if (t.last) begin
                emitted_num = 8'd0;
                emitted_den = 8'd1;
                pending_num = 8'd0;
                pending_den = 8'd1;
                fresh = 1'b1;
            end else if (pending_den == 8'd0) begin
                emitted_num = pending_num;
                emitted_den = pending_den;
                pending_num = 8'd1;
                pending_den = 8'd1;
            end else begin
                k = (n + int'(emitted_den)) / int'(pending_den);
                p = k * int'(pending_num) - int'(emitted_num);
                q = k * int'(pending_den) - int'(emitted_den);
                emitted_num = pending_num;
                emitted_den = pending_den;
                if (q >= 1 && q <= DENOM_MAX && p >= 0 && p < q) begin
                    pending_num = p[7:0];
                    pending_den = q[7:0];
                end else begin
                    pending_num = 8'd1;
                    pending_den = 8'd1;
                end
            end
        end
        return t;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                term_q.insert(term_q.size(), farey_next_term(restart_q.pop_front()));
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (restart_q.size() > 0 && src_idle_pct > 0 &&
                         $urandom_range(1, 100) <= src_idle_pct) begin
                src_gap = $urandom_range(0, 17);
                s_tvalid <= 1'b0;
            end else if (restart_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, restart_q[0]};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // term monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (term_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected term %0d/%0d last %0b",
                                            m_tdata[7:0], m_tdata[15:8], m_tlast));
                end else begin
                    due_term = term_q.pop_front();
                    if (m_tdata[7:0] !== due_term.numer)
                        flag_mismatch($sformatf("numerator %0d, expected %0d",
                                                m_tdata[7:0], due_term.numer));
                    if (m_tdata[15:8] !== due_term.denom)
                        flag_mismatch($sformatf("denominator %0d, expected %0d",
                                                m_tdata[15:8], due_term.denom));
                    if (m_tlast !== due_term.last)
                        flag_mismatch($sformatf("tlast %0b, expected %0b",
                                                m_tlast, due_term.last));
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (sink_idle_pct > 0 && $urandom_range(1, 100) <= sink_idle_pct) begin
                sink_gap = $urandom_range(0, 17);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_requests(input logic restart);
        restart_q.insert(restart_q.size(), restart);
        sent++;
    endtask

    task automatic drain;
        while (restart_q.size() != 0 || term_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_order(input logic [7:0] n);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        order_n = n;
    endtask

    task automatic pick_idling;
        src_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
        sink_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
    endtask

    initial begin
        int pick, count;
        logic [7:0] n;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        pick_idling();

        // order one from reset: 0/1, 1/1, wrap, restart
        foreach (push_list_a[i]) push_requests(push_list_a[i]);
        write_order(8'd0);
        foreach (push_list_b[i]) push_requests(push_list_b[i]);
        write_order(8'd255);
        foreach (push_list_c[i]) push_requests(push_list_c[i]);
        // order change mid-sequence
        write_order(8'd3);
        repeat (6) push_requests(1'b0);

        while (sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                n = 8'd0;
            else if (pick == 1)
                n = 8'd255;
            else if (pick <= 4)
                n = 8'($urandom_range(13, 60));
            else
                n = 8'($urandom_range(1, 12));
            write_order(n);
            if (sent >= QUIET_FROM) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                pick_idling();
            end
            count = (n == 8'd255) ? $urandom_range(10, 40) : $urandom_range(8, 60);
            if ($urandom_range(0, 2) == 0) push_requests(1'b1);
            repeat (count) push_requests($urandom_range(0, 24) == 0);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
